// ===== rtl/ledalu_pkg.sv =====
// ----------------------------------------------------------------------------
// ledalu_pkg
// Types, command and status codes, and helpers shared by the LED register
// ALU and its pin map.
// ----------------------------------------------------------------------------
`default_nettype none

package ledalu_pkg;

   localparam int unsigned LED_WIDTH     = 12;
   localparam int unsigned DATA_WIDTH    = 8;
   localparam int unsigned CTRL_WIDTH    = 4;
   localparam int unsigned OPERAND_WIDTH = 16;

   // Command codes; 14 and 15 are unused and rejected
   typedef enum logic [3:0] {
      CMD_SET = 4'd0,
      CMD_GET = 4'd1,
      CMD_NOT = 4'd2,
      CMD_OR  = 4'd3,
      CMD_AND = 4'd4,
      CMD_XOR = 4'd5,
      CMD_ADD = 4'd6,
      CMD_SUB = 4'd7,
      CMD_INC = 4'd8,
      CMD_DEC = 4'd9,
      CMD_RS  = 4'd10,
      CMD_LS  = 4'd11,
      CMD_RCS = 4'd12,
      CMD_LCS = 4'd13
   } cmd_type;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_NEG_OPERAND = 2'd1,
      STATUS_BAD_COMMAND = 2'd2
   } status_type;

   // Request payload
   typedef struct packed {
      logic [3:0]                       command;
      logic signed [OPERAND_WIDTH-1:0]  operand;
   } req_type;

   // Response payload
   typedef struct packed {
      logic [1:0]            status;
      logic [LED_WIDTH-1:0]  led_value;
      logic [DATA_WIDTH-1:0] data_lines;
      logic [CTRL_WIDTH-1:0] control_lines;
   } rsp_type;

   // x mod 12 for a 15-bit value: 4 * ((x >> 2) mod 3) + (x & 3).
   // The mod 3 part sums base-4 digits, since 4 is 1 mod 3.
   function automatic logic [3:0] mod12(input logic [14:0] x);
      logic [13:0] q;
      logic [4:0]  s;
      logic [2:0]  t;
      logic [1:0]  r3;
      q  = {1'b0, x[14:2]};
      s  = 5'(q[1:0]) + 5'(q[3:2]) + 5'(q[5:4]) + 5'(q[7:6])
         + 5'(q[9:8]) + 5'(q[11:10]) + 5'(q[13:12]);
      t  = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
      if (t >= 3'd6) begin
         t = t - 3'd6;
      end else if (t >= 3'd3) begin
         t = t - 3'd3;
      end
      r3 = t[1:0];
      return {r3, x[1:0]};
   endfunction

   // Pin map: strobe, autofeed and select are inverted, init is direct
   function automatic logic [CTRL_WIDTH-1:0] ctrl_map(input logic [LED_WIDTH-1:0] v);
      return {~v[11], v[10], ~v[9], ~v[8]};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ledalu_core.sv =====
// ----------------------------------------------------------------------------
// ledalu_core
// Combinational command ALU: applies one request to the current LED value
// and builds the response with status and pin map.
// ----------------------------------------------------------------------------
`default_nettype none

module ledalu_core (
   input  var ledalu_pkg::req_type                    req,
   input  var logic [ledalu_pkg::LED_WIDTH-1:0]       led_cur,
   output ledalu_pkg::rsp_type                        rsp
);

   ledalu_pkg::cmd_type                   cmd;
   logic                                  negative;
   logic                                  unary;
   logic [3:0]                            shamt;
   logic [ledalu_pkg::LED_WIDTH-1:0]      op;
   logic [2*ledalu_pkg::LED_WIDTH-1:0]    dbl;
   logic [2*ledalu_pkg::LED_WIDTH-1:0]    dbl_rr;
   logic [2*ledalu_pkg::LED_WIDTH-1:0]    dbl_rl;
   logic [ledalu_pkg::LED_WIDTH-1:0]      nv;
   logic                                  bad_cmd;
   ledalu_pkg::status_type                status;

   // Decode
   assign cmd      = ledalu_pkg::cmd_type'(req.command);
   assign negative = req.operand[ledalu_pkg::OPERAND_WIDTH-1];
   assign unary    = req.command inside {ledalu_pkg::CMD_GET, ledalu_pkg::CMD_NOT,
                                         ledalu_pkg::CMD_INC, ledalu_pkg::CMD_DEC};
   assign shamt    = ledalu_pkg::mod12(req.operand[14:0]);
   assign op       = req.operand[ledalu_pkg::LED_WIDTH-1:0];

   // Rotates work on the value doubled end to end
   assign dbl    = {led_cur, led_cur};
   assign dbl_rr = dbl >> shamt;
   assign dbl_rl = dbl << shamt;

   // Operation select
   always_comb begin
      nv      = led_cur;
      bad_cmd = 1'b0;
      case (cmd)
         ledalu_pkg::CMD_SET: nv = op;
         ledalu_pkg::CMD_GET: nv = led_cur;
         ledalu_pkg::CMD_NOT: nv = ~led_cur;
         ledalu_pkg::CMD_OR:  nv = led_cur | op;
         ledalu_pkg::CMD_AND: nv = led_cur & op;
         ledalu_pkg::CMD_XOR: nv = led_cur ^ op;
         ledalu_pkg::CMD_ADD: nv = led_cur + op;
         ledalu_pkg::CMD_SUB: nv = led_cur - op;
         ledalu_pkg::CMD_INC: nv = led_cur + 12'd1;
         ledalu_pkg::CMD_DEC: nv = led_cur - 12'd1;
         ledalu_pkg::CMD_RS:  nv = led_cur >> shamt;
         ledalu_pkg::CMD_LS:  nv = led_cur << shamt;
         ledalu_pkg::CMD_RCS: nv = dbl_rr[ledalu_pkg::LED_WIDTH-1:0];
         ledalu_pkg::CMD_LCS: nv = dbl_rl[2*ledalu_pkg::LED_WIDTH-1:ledalu_pkg::LED_WIDTH];
         default: begin
            nv      = led_cur;
            bad_cmd = 1'b1;
         end
      endcase
   end

   // Errors keep the register; negative operand wins over unknown command
   always_comb begin
      if (!unary && negative) begin
         status = ledalu_pkg::STATUS_NEG_OPERAND;
      end else if (bad_cmd) begin
         status = ledalu_pkg::STATUS_BAD_COMMAND;
      end else begin
         status = ledalu_pkg::STATUS_OK;
      end
   end

   always_comb begin
      rsp.status        = status;
      rsp.led_value     = (status == ledalu_pkg::STATUS_OK) ? nv : led_cur;
      rsp.data_lines    = rsp.led_value[ledalu_pkg::DATA_WIDTH-1:0];
      rsp.control_lines = ledalu_pkg::ctrl_map(rsp.led_value);
   end

endmodule

`default_nettype wire

// ===== rtl/led_register_alu_with_pin_map_unit.sv =====
// ----------------------------------------------------------------------------
// led_register_alu_with_pin_map_unit
// 12-bit LED register with a command ALU and parallel-port pin map.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid/req_ready/req_data (command, operand).
//   Each request yields exactly one response on rsp_valid/rsp_ready/rsp_data
//   carrying status, the LED value after the command, the data lines and
//   the control lines (strobe, autofeed, select inverted; init direct).
//   A request is captured in an input register, evaluated by the combinational
//   ALU against the LED register and written to the response register, and
//   rsp_valid rises when that register is loaded. The LED register is
//   updated on the same edge, so the next request sees the new value.
//   Throughput is one request per cycle while rsp_ready stays high; the
//   combinational ALU between the input and response registers sets that figure.
//   If the receiver stalls, the response holds and the input register still
//   takes one more request; req_ready then drops until the response moves.
//   Reset clears the LED register to zero and empties both stages.
// ----------------------------------------------------------------------------
`default_nettype none

module led_register_alu_with_pin_map_unit (
   input  var logic                 clock,
   input  var logic                 reset,
   input  var logic                 req_valid,
   output logic                     req_ready,
   input  var ledalu_pkg::req_type  req_data,
   output logic                     rsp_valid,
   input  var logic                 rsp_ready,
   output ledalu_pkg::rsp_type      rsp_data
);

   logic                             in_valid_ff;
   logic                             in_valid_in;
   ledalu_pkg::req_type              in_req_ff;
   logic                             out_valid_ff;
   logic                             out_valid_in;
   ledalu_pkg::rsp_type              out_rsp_ff;
   logic [ledalu_pkg::LED_WIDTH-1:0] led_ff;
   logic [ledalu_pkg::LED_WIDTH-1:0] led_in;
   ledalu_pkg::rsp_type              alu_rsp;
   logic                             advance;
   logic                             req_take;

   // Pipeline flow control
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);
   assign led_in       = advance ? alu_rsp.led_value : led_ff;

   // ALU
   ledalu_core u_core (
      .req     (in_req_ff),
      .led_cur (led_ff),
      .rsp     (alu_rsp)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         led_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         led_ff       <= led_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_req_ff <= req_data;
      end
      if (advance) begin
         out_rsp_ff <= alu_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/ledalu_checker.sv =====
// ----------------------------------------------------------------------------
// ledalu_checker
// Port-level checks for the LED register ALU, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ledalu_checker (
   input var logic                 clock,
   input var logic                 reset,
   input var logic                 req_valid,
   input var logic                 req_ready,
   input var ledalu_pkg::req_type  req_data,
   input var logic                 rsp_valid,
   input var logic                 rsp_ready,
   input var ledalu_pkg::rsp_type  rsp_data
);

   // No response right after reset
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // Stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Data lines follow the low LED bits
   a_data_map: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.data_lines == rsp_data.led_value[7:0])
      else $error("data lines do not match LED value");

   // Control lines follow the pin map
   a_ctrl_map: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.control_lines ==
         {~rsp_data.led_value[11], rsp_data.led_value[10],
          ~rsp_data.led_value[9], ~rsp_data.led_value[8]})
      else $error("control lines do not match LED value");

endmodule

bind led_register_alu_with_pin_map_unit ledalu_checker u_ledalu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
